// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the classifier.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, cond, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== src/eiptc_pkg.sv =====
// Package for the Ethernet/IP transport classifier: widths, codes and types.
// No dependencies.
`timescale 1ns / 1ps
package eiptc_pkg;
    localparam int COUNTER_WIDTH_DEF  = 32;
    localparam int POSITION_WIDTH_DEF = 16;
    localparam int NUM_COUNTERS       = 12;
    localparam logic [3:0] IHL_MASK   = 4'h0F;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        CLS_SHORT = 4'd0,
        CLS_ETH   = 4'd1,
        CLS_ARP   = 4'd2,
        CLS_IPV4  = 4'd3,
        CLS_IPV6  = 4'd4,
        CLS_TCP   = 4'd5,
        CLS_UDP   = 4'd6,
        CLS_ICMP  = 4'd7,
        CLS_HTTP  = 4'd8,
        CLS_HTTPS = 4'd9,
        CLS_DNS   = 4'd10
    } class_t;

    localparam int CNT_TOTAL = 0;
    localparam int CNT_ETH   = 1;
    localparam int CNT_IPV4  = 2;
    localparam int CNT_IPV6  = 3;
    localparam int CNT_TCP   = 4;
    localparam int CNT_UDP   = 5;
    localparam int CNT_ICMP  = 6;
    localparam int CNT_ARP   = 7;
    localparam int CNT_HTTP  = 8;
    localparam int CNT_HTTPS = 9;
    localparam int CNT_DNS   = 10;
    localparam int CNT_OTHER = 11;

    localparam logic [1:0] REG_HTTP  = 2'd0;
    localparam logic [1:0] REG_HTTPS = 2'd1;
    localparam logic [1:0] REG_DNS   = 2'd2;

    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [15:0] ET_IPV6 = 16'h86DD;
    localparam logic [15:0] ET_ARP  = 16'h0806;
    localparam logic [7:0]  NH_TCP   = 8'd6;
    localparam logic [7:0]  NH_UDP   = 8'd17;
    localparam logic [7:0]  NH_ICMP  = 8'd1;
    localparam logic [7:0]  NH_ICMP6 = 8'd58;

    typedef struct packed {
        logic        kind;
        logic [3:0]  pclass;
        logic [15:0] etype;
        logic [2:0]  ipver;
        logic [7:0]  ip_protocol;
        logic [7:0]  ttl;
        logic [15:0] iplen;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  tcp_flags;
        logic [15:0] detail;
        logic [31:0] counter;
    } result_t;
endpackage

// ===== src/ethernet_ip_transport_classifier.sv =====
// Top level of the Ethernet/IP transport classifier: byte capture, classification,
// statistics counters and the output register. Depends on eiptc_pkg, assert_macros.svh.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, opcode..counter_select | to block
//  out     | out_valid, out_stall, result_kind..value   | from block
//  cfg     | cfg_write, cfg_index, cfg_data             | to block
//
// One word is accepted every cycle unless in_stall is high; a result appears in the
// cycle after the word that causes it (the last byte of a frame or a counter read).
// The single output register decides rate: input is taken while it is empty or
// is being drained in the same cycle, so a stalled output stalls input.
// Reset clears the frame state, the counters and restores the default ports.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ethernet_ip_transport_classifier #(
    parameter int COUNTER_WIDTH  = eiptc_pkg::COUNTER_WIDTH_DEF,
    parameter int POSITION_WIDTH = eiptc_pkg::POSITION_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [3:0]  counter_select,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [3:0]  packet_class,
    output logic [15:0] eth_type_code,
    output logic [2:0]  ip_ver,
    output logic [7:0]  ip_protocol,
    output logic [7:0]  ttl_value,
    output logic [15:0] ip_total_len,
    output logic [15:0] source_port,
    output logic [15:0] destination_port,
    output logic [7:0]  tcp_flag_bits,
    output logic [15:0] detail_code,
    output logic [31:0] counter_value
);
    import eiptc_pkg::*;

    localparam logic [POSITION_WIDTH-1:0] PMAX = '1;
    localparam int LW = POSITION_WIDTH + 1;

    logic [15:0] http_reg, https_reg, dns_reg;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] et_reg, et_next, len_reg, len_next, arp_reg, arp_next;
    logic [7:0]  hop_reg, hop_next, proto_reg, proto_next;
    logic [15:0] sp_reg, sp_next, dp_reg, dp_next;
    logic [7:0]  flags_reg, flags_next, icmp_reg, icmp_next;
    logic [COUNTER_WIDTH-1:0] cnt_reg [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0]  bump;
    result_t res_reg, res_next;
    logic    ov_reg;
    logic    accept, produce;

    assign in_stall = ov_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Capture of header bytes at fixed offsets.
    logic [POSITION_WIDTH-1:0] p;
    logic [3:0]  ihl_eff;
    logic [LW-1:0] tstart, t;
    logic is_op_byte;
    always_comb
    begin
        p = pos_reg;
        is_op_byte = accept && (opcode == OP_BYTE);
        ihl_next = ihl_reg; et_next = et_reg; len_next = len_reg; arp_next = arp_reg;
        hop_next = hop_reg; proto_next = proto_reg; sp_next = sp_reg; dp_next = dp_reg;
        flags_next = flags_reg; icmp_next = icmp_reg;
        ihl_eff = (LW'(p) == LW'(14)) ? (data_byte[3:0] & IHL_MASK) : ihl_reg;
        tstart = (et_reg == ET_IPV6) ? LW'(54) : LW'(14) + LW'({ihl_eff, 2'b00});
        t = LW'(p) - tstart;
        if (LW'(p) == LW'(12)) et_next[15:8] = data_byte;
        if (LW'(p) == LW'(13)) et_next[7:0] = data_byte;
        if (LW'(p) == LW'(14)) ihl_next = data_byte[3:0] & IHL_MASK;
        if (LW'(p) >= LW'(14)) begin
            if (et_reg == ET_IPV4) begin
                if (LW'(p) == LW'(16)) len_next[15:8] = data_byte;
                if (LW'(p) == LW'(17)) len_next[7:0] = data_byte;
                if (LW'(p) == LW'(22)) hop_next = data_byte;
                if (LW'(p) == LW'(23)) proto_next = data_byte;
            end else if (et_reg == ET_IPV6) begin
                if (LW'(p) == LW'(18)) len_next[15:8] = data_byte;
                if (LW'(p) == LW'(19)) len_next[7:0] = data_byte;
                if (LW'(p) == LW'(20)) proto_next = data_byte;
                if (LW'(p) == LW'(21)) hop_next = data_byte;
            end else if (et_reg == ET_ARP) begin
                if (LW'(p) == LW'(20)) arp_next[15:8] = data_byte;
                if (LW'(p) == LW'(21)) arp_next[7:0] = data_byte;
            end
            if ((et_reg == ET_IPV4 || et_reg == ET_IPV6) && LW'(p) >= tstart) begin
                if (t == LW'(0)) begin
                    sp_next[15:8] = data_byte;
                    icmp_next = data_byte;
                end
                if (t == LW'(1)) sp_next[7:0] = data_byte;
                if (t == LW'(2)) dp_next[15:8] = data_byte;
                if (t == LW'(3)) dp_next[7:0] = data_byte;
                if (t == LW'(13)) flags_next = data_byte;
            end
        end
        pos_next = pos_reg;
        if (is_op_byte) begin
            if (pos_reg != PMAX) pos_next = pos_reg + 1'b1;
            if (last_byte) begin
                pos_next = '0;
            end
        end
    end

    // Classification on the final byte, from the fields as updated by it, and counter reads.
    logic [LW-1:0] flen, ts2, tlen;
    logic ip_ok, is_tcp, is_udp, icmp_p, tr_ok;
    logic [15:0] spv, dpv;
    always_comb
    begin
        flen = LW'(p) + LW'(1);
        res_next = '0;
        bump = '0;
        ip_ok = 1'b0;
        ts2 = '0;
        tlen = '0;
        spv = sp_next;
        dpv = dp_next;
        is_tcp = (proto_next == NH_TCP);
        is_udp = (proto_next == NH_UDP);
        icmp_p = 1'b0;
        tr_ok = 1'b0;
        produce = 1'b0;
        if (accept && opcode == OP_READ) begin
            produce = 1'b1;
            res_next.kind = 1'b1;
            for (int i = 0; i < NUM_COUNTERS; i++)
                if (counter_select == 4'(i)) res_next.counter = 32'(cnt_reg[i]);
        end else if (is_op_byte && last_byte) begin
            produce = 1'b1;
            bump[CNT_TOTAL] = 1'b1;
            res_next.pclass = CLS_SHORT;
            if (flen >= LW'(14)) begin
                bump[CNT_ETH] = 1'b1;
                res_next.pclass = CLS_ETH;
                res_next.etype = et_next;
                if (et_next == ET_IPV4) begin
                    if (flen >= LW'(34)) begin
                        ip_ok = 1'b1; bump[CNT_IPV4] = 1'b1; res_next.pclass = CLS_IPV4;
                        res_next.ipver = 3'd4;
                        ts2 = LW'(14) + LW'({ihl_next, 2'b00});
                        icmp_p = (proto_next == NH_ICMP);
                    end
                end else if (et_next == ET_IPV6) begin
                    if (flen >= LW'(54)) begin
                        ip_ok = 1'b1; bump[CNT_IPV6] = 1'b1; res_next.pclass = CLS_IPV6;
                        res_next.ipver = 3'd6;
                        ts2 = LW'(54);
                        icmp_p = (proto_next == NH_ICMP6);
                    end
                end else if (et_next == ET_ARP) begin
                    if (flen >= LW'(42)) begin
                        bump[CNT_ARP] = 1'b1; res_next.pclass = CLS_ARP;
                        res_next.detail = arp_next;
                    end
                end else begin
                    bump[CNT_OTHER] = 1'b1;
                end
                if (ip_ok) begin
                    res_next.ip_protocol = proto_next;
                    res_next.ttl = hop_next;
                    res_next.iplen = len_next;
                    tlen = (flen >= ts2) ? flen - ts2 : '0;
                    if (is_tcp || is_udp) begin
                        tr_ok = is_tcp ? (tlen >= LW'(20)) : (tlen >= LW'(8));
                        if (tr_ok) begin
                            res_next.source_port = spv;
                            res_next.destination_port = dpv;
                            if (is_tcp) begin
                                bump[CNT_TCP] = 1'b1; res_next.pclass = CLS_TCP;
                                res_next.tcp_flags = flags_next;
                            end else begin
                                bump[CNT_UDP] = 1'b1; res_next.pclass = CLS_UDP;
                            end
                            if (spv == http_reg || dpv == http_reg) begin
                                bump[CNT_HTTP] = 1'b1; res_next.pclass = CLS_HTTP;
                            end else if (spv == https_reg || dpv == https_reg) begin
                                bump[CNT_HTTPS] = 1'b1; res_next.pclass = CLS_HTTPS;
                            end else if (spv == dns_reg || dpv == dns_reg) begin
                                bump[CNT_DNS] = 1'b1; res_next.pclass = CLS_DNS;
                            end
                        end
                    end else if (icmp_p) begin
                        if (tlen >= LW'(8)) begin
                            bump[CNT_ICMP] = 1'b1; res_next.pclass = CLS_ICMP;
                            res_next.detail = {8'h00, icmp_next};
                        end
                    end else begin
                        bump[CNT_OTHER] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            http_reg <= 16'd80; https_reg <= 16'd443; dns_reg <= 16'd53;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_HTTP:  http_reg <= cfg_data;
                REG_HTTPS: https_reg <= cfg_data;
                REG_DNS:   dns_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0; ihl_reg <= '0; et_reg <= '0; len_reg <= '0; arp_reg <= '0;
            hop_reg <= '0; proto_reg <= '0; sp_reg <= '0; dp_reg <= '0;
            flags_reg <= '0; icmp_reg <= '0;
        end else if (is_op_byte) begin
            pos_reg <= pos_next;
            if (last_byte) begin
                ihl_reg <= '0; et_reg <= '0; len_reg <= '0; arp_reg <= '0;
                hop_reg <= '0; proto_reg <= '0; sp_reg <= '0; dp_reg <= '0;
                flags_reg <= '0; icmp_reg <= '0;
            end else begin
                ihl_reg <= ihl_next; et_reg <= et_next; len_reg <= len_next;
                arp_reg <= arp_next; hop_reg <= hop_next; proto_reg <= proto_next;
                sp_reg <= sp_next; dp_reg <= dp_next; flags_reg <= flags_next;
                icmp_reg <= icmp_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_COUNTERS; i++) cnt_reg[i] <= '0;
        end else if (accept && opcode == OP_CLEAR) begin
            for (int i = 0; i < NUM_COUNTERS; i++) cnt_reg[i] <= '0;
        end else begin
            for (int i = 0; i < NUM_COUNTERS; i++)
                if (bump[i]) cnt_reg[i] <= cnt_reg[i] + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ov_reg <= 1'b0;
        end else if (produce) begin
            ov_reg <= 1'b1;
        end else if (!out_stall) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce) res_reg <= res_next;
    end

    assign out_valid        = ov_reg;
    assign result_kind      = res_reg.kind;
    assign packet_class     = res_reg.pclass;
    assign eth_type_code    = res_reg.etype;
    assign ip_ver           = res_reg.ipver;
    assign ip_protocol      = res_reg.ip_protocol;
    assign ttl_value        = res_reg.ttl;
    assign ip_total_len     = res_reg.iplen;
    assign source_port      = res_reg.source_port;
    assign destination_port = res_reg.destination_port;
    assign tcp_flag_bits    = res_reg.tcp_flags;
    assign detail_code      = res_reg.detail;
    assign counter_value    = res_reg.counter;

    `ASSERT_IMPL(a_stall_only_full, !in_stall || ov_reg, "input stalled with empty output")
    `ASSERT_NEXT(a_read_gives_word, accept && opcode == OP_READ, ov_reg && result_kind,
                 "counter read produced no answer")
    `ASSERT_NEXT(a_last_resets_pos, is_op_byte && last_byte, pos_reg == '0,
                 "byte position not cleared after frame")
    `ASSERT_IMPL(a_bump_total, !(|bump) || bump[CNT_TOTAL], "counter bumped without total")
endmodule
